### rtl/jsu_pkg.sv
`timescale 1ns / 1ps

package jsu_pkg;

  typedef enum logic [1:0] {
    KIND_BYTE  = 2'd0,
    KIND_DONE  = 2'd1,
    KIND_ERROR = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ERR_QUOTE  = 2'd0,
    ERR_END    = 2'd1,
    ERR_HEX    = 2'd2,
    ERR_ESCAPE = 2'd3
  } err_t;

  typedef enum logic [3:0] {
    PH_IDLE   = 4'b0001,
    PH_STRING = 4'b0010,
    PH_ESCAPE = 4'b0100,
    PH_HEX    = 4'b1000
  } phase_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data_byte;
    err_t       error_code;
    logic       last;
  } res_t;

  localparam int ResDepth = 3;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_U      = 8'h75;
  localparam logic [7:0] CH_BS     = 8'h08;
  localparam logic [7:0] CH_FF     = 8'h0C;

  localparam logic [15:0] CP_MAX1 = 16'h007F;
  localparam logic [15:0] CP_MAX2 = 16'h07FF;
  localparam logic [7:0]  LEAD2   = 8'hC0;
  localparam logic [7:0]  LEAD3   = 8'hE0;
  localparam logic [7:0]  CONT    = 8'h80;

endpackage

### rtl/jsu_intf.sv
`timescale 1ns / 1ps

interface jsu_text_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_input;

  modport source (output valid, output in_byte, output end_of_input, input ready);
  modport sink (input valid, input in_byte, input end_of_input, output ready);
endinterface

interface jsu_result_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] data_byte;
  logic [1:0] error_code;
  logic       last;

  modport source (output valid, output kind, output data_byte, output error_code,
                  output last, input ready);
  modport sink (input valid, input kind, input data_byte, input error_code,
                input last, output ready);
endinterface

### rtl/json_string_unescape.sv
`timescale 1ns / 1ps

// channel   dir   payload                                 accepted when
// text      in    in_byte[7:0], end_of_input              text.valid & text.ready
// result    out   kind[1:0], data_byte[7:0],              result.valid & result.ready
//                 error_code[1:0], last
//
// one input byte per cycle while the result buffer keeps up; a byte is decoded in the cycle it is accepted
// a byte that yields k results (k up to 3 for a \u escape) holds text.ready
// low while the three-entry result buffer drains
// the next byte is taken in the same cycle the final buffered result leaves
// synchronous reset clears the parse phase, hex digit count, code point and buffer count
// a stalled result side holds the buffer; text.ready falls once it has one entry

module json_string_unescape (
  input  logic                clk,
  input  logic                rst,
  jsu_text_if.sink            text,
  jsu_result_if.source        result
);
  import jsu_pkg::*;

  phase_t      phase, phase_next;
  logic [1:0]  hex_cnt, hex_cnt_next;
  logic [11:0] code_point, code_point_next;

  res_t        res [ResDepth];
  res_t        res_new [ResDepth];
  logic [1:0]  cnt;
  logic [1:0]  n_new;

  logic        accept;
  logic        pop;
  logic [7:0]  c;
  logic        fin;
  logic        is_hex;
  logic [3:0]  digit;
  logic [15:0] cp_full;

  function automatic res_t mk_byte(input logic [7:0] b, input logic lst);
    res_t r;
    r.kind       = KIND_BYTE;
    r.data_byte  = b;
    r.error_code = ERR_QUOTE;
    r.last       = lst;
    return r;
  endfunction

  function automatic res_t mk_other(input kind_t k, input err_t e);
    res_t r;
    r.kind       = k;
    r.data_byte  = 8'h00;
    r.error_code = e;
    r.last       = 1'b1;
    return r;
  endfunction

  assign c   = text.in_byte;
  assign fin = text.end_of_input || (c == CH_NUL);

  always_comb begin
    is_hex = 1'b1;
    digit  = 4'h0;
    if (c >= 8'h30 && c <= 8'h39) begin
      digit = c[3:0];
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      digit = c[3:0] + 4'd9;
    end else begin
      is_hex = 1'b0;
    end
  end

  assign cp_full = {code_point, digit};

  always_comb begin
    phase_next      = phase;
    hex_cnt_next    = hex_cnt;
    code_point_next = code_point;
    n_new           = 2'd0;
    for (int i = 0; i < ResDepth; i++) begin
      res_new[i] = mk_other(KIND_DONE, ERR_QUOTE);
    end
    unique case (phase)
      PH_IDLE: begin
        if (fin) begin
          res_new[0] = mk_other(KIND_ERROR, ERR_QUOTE);
          n_new      = 2'd1;
        end else if (c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_CR) begin
          n_new = 2'd0;
        end else if (c == CH_QUOTE) begin
          phase_next = PH_STRING;
        end else begin
          res_new[0] = mk_other(KIND_ERROR, ERR_QUOTE);
          n_new      = 2'd1;
        end
      end
      PH_STRING: begin
        if (fin) begin
          res_new[0] = mk_other(KIND_ERROR, ERR_END);
          n_new      = 2'd1;
          phase_next = PH_IDLE;
        end else if (c == CH_QUOTE) begin
          res_new[0] = mk_other(KIND_DONE, ERR_QUOTE);
          n_new      = 2'd1;
          phase_next = PH_IDLE;
        end else if (c == CH_BSLASH) begin
          phase_next = PH_ESCAPE;
        end else begin
          res_new[0] = mk_byte(c, 1'b1);
          n_new      = 2'd1;
        end
      end
      PH_ESCAPE: begin
        if (fin) begin
          res_new[0] = mk_other(KIND_ERROR, ERR_ESCAPE);
          n_new      = 2'd1;
          phase_next = PH_IDLE;
        end else begin
          phase_next = PH_STRING;
          n_new      = 2'd1;
          unique case (c)
            CH_QUOTE, CH_SLASH, CH_BSLASH: res_new[0] = mk_byte(c, 1'b1);
            CH_B: res_new[0] = mk_byte(CH_BS, 1'b1);
            CH_F: res_new[0] = mk_byte(CH_FF, 1'b1);
            CH_N: res_new[0] = mk_byte(CH_LF, 1'b1);
            CH_R: res_new[0] = mk_byte(CH_CR, 1'b1);
            CH_T: res_new[0] = mk_byte(CH_TAB, 1'b1);
            CH_U: begin
              n_new           = 2'd0;
              phase_next      = PH_HEX;
              hex_cnt_next    = 2'd0;
              code_point_next = 12'h000;
            end
            default: begin
              res_new[0] = mk_other(KIND_ERROR, ERR_ESCAPE);
              phase_next = PH_IDLE;
            end
          endcase
        end
      end
      PH_HEX: begin
        if (fin || !is_hex) begin
          res_new[0]      = mk_other(KIND_ERROR, ERR_HEX);
          n_new           = 2'd1;
          phase_next      = PH_IDLE;
          hex_cnt_next    = 2'd0;
          code_point_next = 12'h000;
        end else if (hex_cnt != 2'd3) begin
          hex_cnt_next    = hex_cnt + 2'd1;
          code_point_next = cp_full[11:0];
        end else begin
          phase_next      = PH_STRING;
          hex_cnt_next    = 2'd0;
          code_point_next = 12'h000;
          // utf-8 length follows the code point range
          if (cp_full <= CP_MAX1) begin
            res_new[0] = mk_byte(cp_full[7:0], 1'b1);
            n_new      = 2'd1;
          end else if (cp_full <= CP_MAX2) begin
            res_new[0] = mk_byte(LEAD2 | {3'b000, cp_full[10:6]}, 1'b0);
            res_new[1] = mk_byte(CONT | {2'b00, cp_full[5:0]}, 1'b1);
            n_new      = 2'd2;
          end else begin
            res_new[0] = mk_byte(LEAD3 | {4'h0, cp_full[15:12]}, 1'b0);
            res_new[1] = mk_byte(CONT | {2'b00, cp_full[11:6]}, 1'b0);
            res_new[2] = mk_byte(CONT | {2'b00, cp_full[5:0]}, 1'b1);
            n_new      = 2'd3;
          end
        end
      end
      default: begin
        phase_next      = PH_IDLE;
        hex_cnt_next    = 2'd0;
        code_point_next = 12'h000;
      end
    endcase
  end

  // a new request is taken once the buffer is empty or its final entry leaves now
  assign pop        = result.valid && result.ready;
  assign text.ready = (cnt == 2'd0) || (cnt == 2'd1 && result.ready);
  assign accept     = text.valid && text.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      hex_cnt    <= 2'd0;
      code_point <= 12'h000;
      cnt        <= 2'd0;
    end else begin
      if (accept) begin
        phase      <= phase_next;
        hex_cnt    <= hex_cnt_next;
        code_point <= code_point_next;
        cnt        <= n_new;
      end else if (pop) begin
        cnt <= cnt - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      for (int i = 0; i < ResDepth; i++) begin
        res[i] <= res_new[i];
      end
    end else if (pop) begin
      for (int i = 0; i < ResDepth - 1; i++) begin
        res[i] <= res[i + 1];
      end
    end
  end

  assign result.valid      = (cnt != 2'd0);
  assign result.kind       = res[0].kind;
  assign result.data_byte  = res[0].data_byte;
  assign result.error_code = res[0].error_code;
  assign result.last       = res[0].last;

  a_no_take_while_backed_up: assert property (@(posedge clk) disable iff (rst)
    (cnt > 2'd1) |-> !text.ready)
    else $error("request taken while several results pending");

  a_last_on_final_entry: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.last) |-> (cnt == 2'd1))
    else $error("last flag on a result that is not the final buffered one");

  a_error_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.kind == KIND_ERROR) |-> (phase == PH_IDLE))
    else $error("error result pending but parser not idle");

  a_digits_only_in_hex: assert property (@(posedge clk) disable iff (rst)
    (hex_cnt != 2'd0) |-> (phase == PH_HEX))
    else $error("hex digit count set outside a unicode escape");

  a_quote_opens_string: assert property (@(posedge clk) disable iff (rst)
    (accept && phase == PH_IDLE && !fin && c == CH_QUOTE) |=> (phase == PH_STRING))
    else $error("opening quote did not enter a string");

endmodule

### test/json_string_unescape_check.sv
`timescale 1ns / 1ps

module json_string_unescape_check (
  input  logic   clk,
  input  logic   rst,
  jsu_text_if    text,
  jsu_result_if  result,
  output int     fail_count,
  output int     pending
);
  import jsu_pkg::*;

  // parser state as seen from outside
  phase_t      ph;
  logic [1:0]  hex_cnt;
  logic [15:0] cp;

  res_t decoded_q[$];

  function automatic void emit(kind_t k, logic [7:0] d, err_t e);
    res_t r;
    r.kind       = k;
    r.data_byte  = d;
    r.error_code = e;
    r.last       = 1'b0;
    decoded_q = {decoded_q, r};
  endfunction

  function automatic void fault(err_t e);
    ph      = PH_IDLE;
    hex_cnt = '0;
    cp      = '0;
    emit(KIND_ERROR, 8'h00, e);
  endfunction

  function automatic logic [4:0] hex_nibble(input logic [7:0] c);
    if (c >= "0" && c <= "9") return {1'b1, 4'(c - "0")};
    if (c >= "a" && c <= "f") return {1'b1, 4'(c - "a" + 8'd10)};
    if (c >= "A" && c <= "F") return {1'b1, 4'(c - "A" + 8'd10)};
    return 5'd0;
  endfunction

  // error_code stays at zero (ERR_QUOTE) on byte and done results
  function automatic void unescape_byte(input logic [7:0] c, input logic eoi);
    logic       fin;
    logic [4:0] nib;
    int         base;
    res_t       r;
    fin  = eoi || (c == CH_NUL);
    base = decoded_q.size();
    case (ph)
      PH_IDLE: begin
        if (fin) fault(ERR_QUOTE);
        else if (c == CH_QUOTE) ph = PH_STRING;
        else if (!(c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_CR)) fault(ERR_QUOTE);
      end
      PH_STRING: begin
        if (fin) fault(ERR_END);
        else if (c == CH_QUOTE) begin
          ph = PH_IDLE;
          emit(KIND_DONE, 8'h00, ERR_QUOTE);
        end else if (c == CH_BSLASH) ph = PH_ESCAPE;
        else emit(KIND_BYTE, c, ERR_QUOTE);
      end
      PH_ESCAPE: begin
        if (fin) fault(ERR_ESCAPE);
        else begin
          ph = PH_STRING;
          case (c)
            CH_QUOTE, CH_SLASH, CH_BSLASH: emit(KIND_BYTE, c, ERR_QUOTE);
            CH_B: emit(KIND_BYTE, CH_BS, ERR_QUOTE);
            CH_F: emit(KIND_BYTE, CH_FF, ERR_QUOTE);
            CH_N: emit(KIND_BYTE, CH_LF, ERR_QUOTE);
            CH_R: emit(KIND_BYTE, CH_CR, ERR_QUOTE);
            CH_T: emit(KIND_BYTE, CH_TAB, ERR_QUOTE);
            CH_U: begin
              ph      = PH_HEX;
              hex_cnt = '0;
              cp      = '0;
            end
            default: fault(ERR_ESCAPE);
          endcase
        end
      end
      PH_HEX: begin
        nib = fin ? 5'd0 : hex_nibble(c);
        if (!nib[4]) fault(ERR_HEX);
        else begin
          cp = {cp[11:0], nib[3:0]};
          if (hex_cnt < 2'd3) hex_cnt = hex_cnt + 2'd1;
          else begin
            // utf-8 of one, two or three bytes; surrogates encoded as is
            if (cp <= CP_MAX1) emit(KIND_BYTE, cp[7:0], ERR_QUOTE);
            else if (cp <= CP_MAX2) begin
              emit(KIND_BYTE, LEAD2 | {3'b000, cp[10:6]}, ERR_QUOTE);
              emit(KIND_BYTE, CONT | {2'b00, cp[5:0]}, ERR_QUOTE);
            end else begin
              emit(KIND_BYTE, LEAD3 | {4'b0000, cp[15:12]}, ERR_QUOTE);
              emit(KIND_BYTE, CONT | {2'b00, cp[11:6]}, ERR_QUOTE);
              emit(KIND_BYTE, CONT | {2'b00, cp[5:0]}, ERR_QUOTE);
            end
            ph      = PH_STRING;
            hex_cnt = '0;
            cp      = '0;
          end
        end
      end
      default: ph = PH_IDLE;
    endcase
    if (decoded_q.size() > base) begin
      r      = decoded_q.pop_back();
      r.last = 1'b1;
      decoded_q = {decoded_q, r};
    end
  endfunction

  always @(posedge clk) begin
    res_t want;
    if (rst) begin
      ph         = PH_IDLE;
      hex_cnt    = '0;
      cp         = '0;
      fail_count = 0;
      decoded_q.delete();
    end else begin
      // take the request first so a same-edge result still finds its entry
      if (text.valid && text.ready) unescape_byte(text.in_byte, text.end_of_input);
      if (result.valid && result.ready) begin
        if (decoded_q.size() == 0) begin
          $error("unexpected result: kind %0d data_byte %02h error_code %0d last %0b",
                 result.kind, result.data_byte, result.error_code, result.last);
          fail_count++;
        end else begin
          want = decoded_q.pop_front();
          if (result.kind !== want.kind) begin
            $error("kind: expected %0d, got %0d", want.kind, result.kind);
            fail_count++;
          end
          if (result.data_byte !== want.data_byte) begin
            $error("data_byte: expected %02h, got %02h", want.data_byte, result.data_byte);
            fail_count++;
          end
          if (result.error_code !== want.error_code) begin
            $error("error_code: expected %0d, got %0d", want.error_code, result.error_code);
            fail_count++;
          end
          if (result.last !== want.last) begin
            $error("last: expected %0b, got %0b", want.last, result.last);
            fail_count++;
          end
        end
      end
    end
    pending = decoded_q.size();
  end

endmodule

### test/json_string_unescape_test.sv
`timescale 1ns / 1ps

module json_string_unescape_test;
  import jsu_pkg::*;

  localparam int QuietLimit = 2000;
  localparam int NumBytes   = 500;

  localparam logic [7:0] WS_CHARS [4] = '{CH_SPACE, CH_TAB, CH_LF, CH_CR};
  localparam logic [7:0] ESC_CHARS [8] = '{CH_QUOTE, CH_SLASH, CH_BSLASH, CH_B,
                                           CH_F, CH_N, CH_R, CH_T};

  logic clk;
  logic rst;
  logic stall_on;
  int   fail_count;
  int   pending;
  int   quiet_cycles;
  int   sent;

  jsu_text_if   text();
  jsu_result_if result();

  json_string_unescape u_top (
    .clk    (clk),
    .rst    (rst),
    .text   (text),
    .result (result)
  );

  json_string_unescape_check u_check (
    .clk        (clk),
    .rst        (rst),
    .text       (text),
    .result     (result),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  always @(posedge clk) begin
    result.ready <= !rst && (!stall_on || $urandom_range(99) >= 38);
  end

  // ends the run if nothing moves on either channel for too long
  always @(posedge clk) begin
    if (rst || (text.valid && text.ready) || (result.valid && result.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic put_byte(input logic [7:0] b, input logic eoi = 1'b0);
    bit taken;
    taken = 1'b0;
    while (stall_on && $urandom_range(99) < 38) begin
      text.valid <= 1'b0;
      @(posedge clk);
    end
    text.valid        <= 1'b1;
    text.in_byte      <= b;
    text.end_of_input <= eoi;
    // ready is settled by the falling edge, the request moves on the next rising one
    while (!taken) begin
      @(negedge clk);
      taken = text.ready;
      @(posedge clk);
    end
    sent++;
  endtask

  task automatic drain();
    text.valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] v);
    if (v < 4'd10) return "0" + 8'(v);
    return ($urandom_range(1) ? "a" : "A") + 8'(v) - 8'd10;
  endfunction

  task automatic put_hex_escape(input logic [15:0] cpv);
    put_byte(CH_BSLASH);
    put_byte(CH_U);
    for (int i = 3; i >= 0; i--) put_byte(hex_char(cpv[4*i +: 4]));
  endtask

  // mostly a well formed string with random content, sometimes ending in a fault
  task automatic put_string();
    logic [7:0]  b;
    logic [15:0] cpv;
    int          sel;
    repeat ($urandom_range(2)) put_byte(WS_CHARS[$urandom_range(3)]);
    put_byte(CH_QUOTE);
    repeat ($urandom_range(6)) begin
      sel = $urandom_range(99);
      if (sel < 55) begin
        do b = 8'($urandom_range(1, 255)); while (b == CH_QUOTE || b == CH_BSLASH);
        put_byte(b);
      end else if (sel < 80) begin
        put_byte(CH_BSLASH);
        put_byte(ESC_CHARS[$urandom_range(7)]);
      end else begin
        case ($urandom_range(4))
          0: cpv = 16'($urandom_range(16'h007F));
          1: cpv = 16'($urandom_range(16'h0080, 16'h07FF));
          2: cpv = 16'($urandom_range(16'h0800, 16'hFFFF));
          3: begin
            case ($urandom_range(5))
              0: cpv = 16'h0000;
              1: cpv = CP_MAX1;
              2: cpv = 16'h0080;
              3: cpv = CP_MAX2;
              4: cpv = 16'h0800;
              default: cpv = 16'hFFFF;
            endcase
          end
          default: cpv = 16'($urandom);
        endcase
        put_hex_escape(cpv);
      end
    end
    if ($urandom_range(99) < 75) begin
      put_byte(CH_QUOTE);
    end else begin
      case ($urandom_range(5))
        0: put_byte(CH_NUL);
        1: put_byte(8'($urandom), 1'b1);
        2: begin
          put_byte(CH_BSLASH);
          do b = 8'($urandom);
          while (b inside {CH_QUOTE, CH_SLASH, CH_BSLASH, CH_B, CH_F, CH_N, CH_R, CH_T, CH_U});
          put_byte(b);
        end
        3: begin
          put_byte(CH_BSLASH);
          put_byte(8'($urandom), 1'b1);
        end
        4: begin
          put_byte(CH_BSLASH);
          put_byte(CH_U);
          repeat ($urandom_range(3)) put_byte(hex_char(4'($urandom)));
          do b = 8'($urandom); while (b inside {["0":"9"], ["a":"f"], ["A":"F"]});
          put_byte(b);
        end
        default: begin
          put_byte(CH_BSLASH);
          put_byte(CH_U);
          repeat ($urandom_range(3)) put_byte(hex_char(4'($urandom)));
          put_byte(8'($urandom), 1'b1);
        end
      endcase
    end
  endtask

  initial begin
    bit paused;
    paused            = 1'b0;
    sent              = 0;
    stall_on          = 1'b1;
    rst               = 1'b1;
    text.valid        = 1'b0;
    text.in_byte      = 8'h00;
    text.end_of_input = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // whitespace at idle, stray byte, end at idle
    put_byte(CH_SPACE);
    put_byte(CH_TAB);
    put_byte(CH_LF);
    put_byte(CH_CR);
    put_byte("a");
    put_byte(8'hFF, 1'b1);
    // high byte, largest code point in mixed case, unknown escape
    put_byte(CH_QUOTE);
    put_byte(8'hFF);
    put_byte(CH_BSLASH);
    put_byte(CH_U);
    put_byte("F");
    put_byte("f");
    put_byte("f");
    put_byte("F");
    put_byte(CH_BSLASH);
    put_byte("x");
    // zero code point, then a zero byte inside a string
    put_byte(CH_QUOTE);
    put_hex_escape(16'h0000);
    put_byte(CH_NUL);
    // empty string
    put_byte(CH_QUOTE);
    put_byte(CH_QUOTE);
    drain();

    while (sent < NumBytes) begin
      stall_on <= (sent < 200 || sent >= 300);
      if (!paused && sent >= 250) begin
        paused = 1'b1;
        drain();
      end
      if ($urandom_range(99) < 85) put_string();
      else put_byte(8'($urandom), $urandom_range(9) == 0);
    end

    drain();
    repeat (20) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
